// File: rtl/tard_pkg.sv
// ---------------------------------------------------------------------------
// tard_pkg
// Shared types and constants for the tilt detector: controller commands,
// datapath status, rate-hold counter widths and the hold limit reset value.
// ---------------------------------------------------------------------------
package tard_pkg;

  localparam int unsigned HOLD_W  = 9;
  localparam int unsigned LIMIT_W = 8;
  localparam logic [LIMIT_W-1:0] HOLD_LIMIT_RESET = 8'd10;

  typedef struct packed {
    logic capture;
    logic sq_a;
    logic sq_b;
    logic dot;
    logic acc;
    logic prd;
    logic dsq;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic ref_valid;
    logic out_free;
  } sts_t;

endpackage

// File: rtl/tard_ctrl.sv
// ---------------------------------------------------------------------------
// tard_ctrl
// Sequencer for the tilt detector: steps the datapath through the square,
// dot product, wide product and decision steps of one word; the reference word goes straight to the decision step.
// ---------------------------------------------------------------------------
module tard_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  tard_pkg::sts_t   sts,
  output tard_pkg::cmd_t   cmd
);

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_SQA  = 8'b0000_0010,
    ST_SQB  = 8'b0000_0100,
    ST_DOT  = 8'b0000_1000,
    ST_ACC  = 8'b0001_0000,
    ST_PRD  = 8'b0010_0000,
    ST_DSQ  = 8'b0100_0000,
    ST_FIN  = 8'b1000_0000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.ref_valid ? ST_SQA : ST_FIN;
        end
      end
      ST_SQA: state_nxt = ST_SQB;
      ST_SQB: state_nxt = ST_DOT;
      ST_DOT: state_nxt = ST_ACC;
      ST_ACC: state_nxt = ST_PRD;
      ST_PRD: state_nxt = ST_DSQ;
      ST_DSQ: state_nxt = ST_FIN;
      ST_FIN: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    cmd         = '0;
    cmd.capture = (state_r == ST_IDLE) && in_valid;
    cmd.sq_a    = (state_r == ST_SQA);
    cmd.sq_b    = (state_r == ST_SQB);
    cmd.dot     = (state_r == ST_DOT);
    cmd.acc     = (state_r == ST_ACC);
    cmd.prd     = (state_r == ST_PRD);
    cmd.dsq     = (state_r == ST_DSQ);
    cmd.finish  = (state_r == ST_FIN) && sts.out_free;
  end

endmodule

// File: rtl/tard_dp.sv
// ---------------------------------------------------------------------------
// tard_dp
// Datapath for the tilt detector: axis unpacking, three signed multiplier
// lanes with an adder, one shared wide multiplier, the 45 degree compare,
// the rate-hold logic and the output register.
// ---------------------------------------------------------------------------
module tard_dp #(
  parameter int unsigned SAMPLE_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tard_pkg::cmd_t                cmd,
  output tard_pkg::sts_t                sts,
  input  logic                          cfg_we,
  input  logic [tard_pkg::LIMIT_W-1:0]  cfg_wdata,
  input  logic [7:0]                    in_x_high_byte,
  input  logic [7:0]                    in_x_low_byte,
  input  logic [7:0]                    in_y_high_byte,
  input  logic [7:0]                    in_y_low_byte,
  input  logic [7:0]                    in_z_high_byte,
  input  logic [7:0]                    in_z_low_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_accel_x,
  output logic signed [SAMPLE_BITS-1:0] out_accel_y,
  output logic signed [SAMPLE_BITS-1:0] out_accel_z,
  output logic                          out_tilted,
  output logic                          out_fast_rate,
  output logic                          out_reference_taken
);

  localparam int unsigned S  = SAMPLE_BITS;
  localparam int unsigned PW = 2 * S;
  localparam int unsigned SW = 2 * S + 2;
  localparam int unsigned LW = 2 * S;
  localparam int unsigned BW = 2 * LW;

  logic [15:0] raw_x, raw_y, raw_z;

  logic signed [S-1:0]  smp_r [3];
  logic signed [S-1:0]  ref_r [3];
  logic signed [PW-1:0] prod_r [3];
  logic signed [S-1:0]  opa [3];
  logic signed [S-1:0]  opb [3];
  logic signed [SW-1:0] sum;

  logic [LW-1:0]        la_r, lb_r;
  logic signed [SW-1:0] dot_r;
  logic [LW-1:0]        big_a, big_b;
  logic [BW-1:0]        big_p;
  logic [BW-1:0]        lab_r, d2_r;
  logic                 tilt;

  logic                          ref_valid_r;
  logic                          fast_r, fast_nxt;
  logic [tard_pkg::HOLD_W-1:0]   hold_r, hold_nxt, hold_inc;
  logic [tard_pkg::LIMIT_W-1:0]  limit_r;
  logic                          fast_set;

  logic                  out_valid_r;
  logic signed [S-1:0]   out_x_r, out_y_r, out_z_r;
  logic                  out_tilt_r, out_fast_r, out_took_r;

  // axis unpacking, low bits below the sample dropped
  assign raw_x = {in_x_high_byte, in_x_low_byte} >> (16 - S);
  assign raw_y = {in_y_high_byte, in_y_low_byte} >> (16 - S);
  assign raw_z = {in_z_high_byte, in_z_low_byte} >> (16 - S);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      smp_r[0] <= $signed(raw_x[S-1:0]);
      smp_r[1] <= $signed(raw_y[S-1:0]);
      smp_r[2] <= $signed(raw_z[S-1:0]);
    end
  end

  // multiplier lanes
  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign opa[i] = cmd.sq_b ? ref_r[i] : smp_r[i];
    assign opb[i] = cmd.sq_a ? smp_r[i] : ref_r[i];

    always_ff @(posedge clk) begin
      if (cmd.sq_a || cmd.sq_b || cmd.dot) begin
        prod_r[i] <= opa[i] * opb[i];
      end
    end
  end

  assign sum = SW'(prod_r[0]) + SW'(prod_r[1]) + SW'(prod_r[2]);

  always_ff @(posedge clk) begin
    if (cmd.sq_b) begin
      la_r <= sum[LW-1:0];
    end
    if (cmd.dot) begin
      lb_r <= sum[LW-1:0];
    end
    if (cmd.acc) begin
      dot_r <= sum;
    end
  end

  // shared wide multiplier: |a|^2 * |b|^2, then dot^2
  assign big_a = cmd.prd ? la_r : dot_r[LW-1:0];
  assign big_b = cmd.prd ? lb_r : dot_r[LW-1:0];
  assign big_p = BW'(big_a) * BW'(big_b);

  always_ff @(posedge clk) begin
    if (cmd.prd) begin
      lab_r <= big_p;
    end
    if (cmd.dsq) begin
      d2_r <= big_p;
    end
  end

  assign tilt = (la_r != '0) && (lb_r != '0) &&
                (dot_r[SW-1] || (dot_r == '0) || ({d2_r, 1'b0} <= {1'b0, lab_r}));

  // rate-hold logic
  assign fast_set = fast_r || tilt;
  assign hold_inc = fast_set ? hold_r + 1'b1 : hold_r;

  always_comb begin
    fast_nxt = fast_set;
    hold_nxt = hold_inc;
    if (hold_inc > tard_pkg::HOLD_W'(limit_r)) begin
      fast_nxt = 1'b0;
      hold_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_valid_r <= 1'b0;
      fast_r      <= 1'b0;
      hold_r      <= '0;
      limit_r     <= tard_pkg::HOLD_LIMIT_RESET;
      ref_r[0]    <= '0;
      ref_r[1]    <= '0;
      ref_r[2]    <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      if (cmd.finish) begin
        if (!ref_valid_r) begin
          ref_valid_r <= 1'b1;
          ref_r[0]    <= smp_r[0];
          ref_r[1]    <= smp_r[1];
          ref_r[2]    <= smp_r[2];
        end else begin
          fast_r <= fast_nxt;
          hold_r <= hold_nxt;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_x_r    <= smp_r[0];
      out_y_r    <= smp_r[1];
      out_z_r    <= smp_r[2];
      out_took_r <= !ref_valid_r;
      out_tilt_r <= ref_valid_r && tilt;
      out_fast_r <= ref_valid_r ? fast_nxt : fast_r;
    end
  end

  assign sts.ref_valid = ref_valid_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid           = out_valid_r;
  assign out_accel_x         = out_x_r;
  assign out_accel_y         = out_y_r;
  assign out_accel_z         = out_z_r;
  assign out_tilted          = out_tilt_r;
  assign out_fast_rate       = out_fast_r;
  assign out_reference_taken = out_took_r;

endmodule

// File: rtl/tilt_adaptive_rate_detector.sv
// ---------------------------------------------------------------------------
// tilt_adaptive_rate_detector
// Accelerometer tilt detector with fast/slow sampling rate selection.
//
// Input channel (in_valid / in_stall): one word of six raw axis register
// bytes. Output channel (out_valid / out_stall): signed axes, the tilt flag,
// the rate selection and a flag for the word that became the reference.
// Configuration: cfg_we writes cfg_wdata into the hold limit (reset 10).
//
// The first word after reset is stored as the reference and goes straight
// to the final step, where its result is registered. Every later word runs
// through the sequencer: squares, dot product, two wide products and the
// decision, with its result registered in the final step. One word is in
// work at a time, as the three multiplier lanes and the single shared wide
// multiplier are reused by its steps; the next word waits until it ends.
// A finished result sits in the output register while the next word is
// accepted; if the receiver still stalls when the next result is ready, the
// sequencer holds in its last step until the register frees.
// Synchronous active-low reset clears the reference, the rate mode, the
// hold counter and the output valid.
// ---------------------------------------------------------------------------
module tilt_adaptive_rate_detector #(
  parameter int unsigned SAMPLE_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [7:0]                    cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    in_x_high_byte,
  input  logic [7:0]                    in_x_low_byte,
  input  logic [7:0]                    in_y_high_byte,
  input  logic [7:0]                    in_y_low_byte,
  input  logic [7:0]                    in_z_high_byte,
  input  logic [7:0]                    in_z_low_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_accel_x,
  output logic signed [SAMPLE_BITS-1:0] out_accel_y,
  output logic signed [SAMPLE_BITS-1:0] out_accel_z,
  output logic                          out_tilted,
  output logic                          out_fast_rate,
  output logic                          out_reference_taken
);

  tard_pkg::cmd_t cmd;
  tard_pkg::sts_t sts;

  tard_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tard_dp #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_x_high_byte      (in_x_high_byte),
    .in_x_low_byte       (in_x_low_byte),
    .in_y_high_byte      (in_y_high_byte),
    .in_y_low_byte       (in_y_low_byte),
    .in_z_high_byte      (in_z_high_byte),
    .in_z_low_byte       (in_z_low_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_accel_x         (out_accel_x),
    .out_accel_y         (out_accel_y),
    .out_accel_z         (out_accel_z),
    .out_tilted          (out_tilted),
    .out_fast_rate       (out_fast_rate),
    .out_reference_taken (out_reference_taken)
  );

endmodule

// File: tb/tilt_checker.sv
// ---------------------------------------------------------------------------
// tilt_checker
// Watches the input, output and hold-limit ports of the tilt detector. Every
// accepted input word is run through a bit-exact integer model of the tilt
// decision and the fast/slow rate hold, and the expected result is queued.
// Each accepted output word is compared field by field with the oldest
// queued result. Mismatches are counted and handed to the testbench top.
// ---------------------------------------------------------------------------
module tilt_checker #(
  parameter int unsigned SAMPLE_BITS = 14
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [7:0]                    cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [7:0]                    in_x_high_byte,
  input  logic [7:0]                    in_x_low_byte,
  input  logic [7:0]                    in_y_high_byte,
  input  logic [7:0]                    in_y_low_byte,
  input  logic [7:0]                    in_z_high_byte,
  input  logic [7:0]                    in_z_low_byte,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [SAMPLE_BITS-1:0] out_accel_x,
  input  logic signed [SAMPLE_BITS-1:0] out_accel_y,
  input  logic signed [SAMPLE_BITS-1:0] out_accel_z,
  input  logic                          out_tilted,
  input  logic                          out_fast_rate,
  input  logic                          out_reference_taken,
  output int                            mismatches,
  output int                            outstanding,
  output int                            n_compared,
  output int                            n_tilted,
  output int                            n_fast
);

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] ax;
    logic signed [SAMPLE_BITS-1:0] ay;
    logic signed [SAMPLE_BITS-1:0] az;
    logic                          tilted;
    logic                          fast;
    logic                          took;
  } tilt_result_t;

  tilt_result_t                  expected_q[$];
  logic signed [SAMPLE_BITS-1:0] ref_ax, ref_ay, ref_az;
  logic                          have_ref;
  logic                          fast_mode;
  logic [tard_pkg::HOLD_W-1:0]   hold_cnt;
  logic [tard_pkg::LIMIT_W-1:0]  hold_limit;

  initial begin
    mismatches  = 0;
    outstanding = 0;
    n_compared  = 0;
    n_tilted    = 0;
    n_fast      = 0;
  end

  function automatic logic signed [SAMPLE_BITS-1:0] axis_from_bytes(logic [7:0] hi,
                                                                    logic [7:0] lo);
    logic [15:0] w;
    w = {hi, lo};
    return w[15 -: SAMPLE_BITS];
  endfunction

  // angle to reference of at least 45 degrees, exact integer form
  function automatic logic angle_at_least_45(longint x, longint y, longint z);
    longint la, lb, dot;
    la = x * x + y * y + z * z;
    lb = longint'(ref_ax) * ref_ax + longint'(ref_ay) * ref_ay + longint'(ref_az) * ref_az;
    if (la == 0 || lb == 0) return 1'b0;
    dot = x * ref_ax + y * ref_ay + z * ref_az;
    if (dot <= 0) return 1'b1;
    return (dot * dot) <= (la * lb) / 2;
  endfunction

  function automatic tilt_result_t next_result(logic [7:0] xh, logic [7:0] xl,
                                               logic [7:0] yh, logic [7:0] yl,
                                               logic [7:0] zh, logic [7:0] zl);
    tilt_result_t r;
    r.ax     = axis_from_bytes(xh, xl);
    r.ay     = axis_from_bytes(yh, yl);
    r.az     = axis_from_bytes(zh, zl);
    r.tilted = 1'b0;
    r.took   = 1'b0;
    if (!have_ref) begin
      ref_ax   = r.ax;
      ref_ay   = r.ay;
      ref_az   = r.az;
      have_ref = 1'b1;
      r.took   = 1'b1;
    end else begin
      r.tilted = angle_at_least_45(r.ax, r.ay, r.az);
      if (r.tilted) fast_mode = 1'b1;
      if (fast_mode) hold_cnt = hold_cnt + 1'b1;
      if (hold_cnt > hold_limit) begin
        fast_mode = 1'b0;
        hold_cnt  = '0;
      end
    end
    r.fast = fast_mode;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatches++;
    $display("mismatch on %s at result %0d: got %0d, want %0d", what, n_compared, got, want);
  endtask

  always @(posedge clk) begin
    tilt_result_t want;
    if (!rst_n) begin
      expected_q.delete();
      ref_ax     = '0;
      ref_ay     = '0;
      ref_az     = '0;
      have_ref   = 1'b0;
      fast_mode  = 1'b0;
      hold_cnt   = '0;
      hold_limit = tard_pkg::HOLD_LIMIT_RESET;
    end else begin
      if (cfg_we) hold_limit = cfg_wdata;
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected word", 1, 0);
        end else begin
          want = expected_q.pop_front();
          if (out_accel_x !== want.ax) report_mismatch("accel_x", out_accel_x, want.ax);
          if (out_accel_y !== want.ay) report_mismatch("accel_y", out_accel_y, want.ay);
          if (out_accel_z !== want.az) report_mismatch("accel_z", out_accel_z, want.az);
          if (out_tilted !== want.tilted)
            report_mismatch("tilted", out_tilted, want.tilted);
          if (out_fast_rate !== want.fast)
            report_mismatch("fast_rate", out_fast_rate, want.fast);
          if (out_reference_taken !== want.took)
            report_mismatch("reference_taken", out_reference_taken, want.took);
          n_compared++;
          if (want.tilted) n_tilted++;
          if (want.fast) n_fast++;
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(next_result(in_x_high_byte, in_x_low_byte, in_y_high_byte,
                                         in_y_low_byte, in_z_high_byte, in_z_low_byte));
    end
    outstanding <= expected_q.size();
  end

endmodule

// File: tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// Testbench for the tilt detector. A directed opening sets the reference and
// walks through zero-length, opposite, perpendicular, exact 45-degree and
// near-45-degree vectors and a full fast-mode hold. Random words then follow
// under several hold limits, 0 and 255 among them, with three sender/receiver
// idling profiles. Prediction and comparison live in tilt_checker.
// ---------------------------------------------------------------------------
module tb;

  localparam int unsigned SAMPLE_BITS    = 14;
  localparam int          AXIS_MAX       = (1 << (SAMPLE_BITS - 1)) - 1;
  localparam int          AXIS_MIN       = -(1 << (SAMPLE_BITS - 1));
  localparam int          ONE_G          = 4096;
  localparam int          WATCHDOG_LIMIT = 5000;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [7:0]                    cfg_wdata = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [7:0]                    in_x_high_byte = '0;
  logic [7:0]                    in_x_low_byte = '0;
  logic [7:0]                    in_y_high_byte = '0;
  logic [7:0]                    in_y_low_byte = '0;
  logic [7:0]                    in_z_high_byte = '0;
  logic [7:0]                    in_z_low_byte = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_accel_x, out_accel_y, out_accel_z;
  logic                          out_tilted, out_fast_rate, out_reference_taken;

  int mismatches, outstanding, n_compared, n_tilted, n_fast;
  int send_idle_pct = 7;
  int recv_stall_pct = 58;
  int words_sent = 0;
  int quiet_cycles = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  tilt_adaptive_rate_detector #(.SAMPLE_BITS(SAMPLE_BITS)) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_x_high_byte      (in_x_high_byte),
    .in_x_low_byte       (in_x_low_byte),
    .in_y_high_byte      (in_y_high_byte),
    .in_y_low_byte       (in_y_low_byte),
    .in_z_high_byte      (in_z_high_byte),
    .in_z_low_byte       (in_z_low_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_accel_x         (out_accel_x),
    .out_accel_y         (out_accel_y),
    .out_accel_z         (out_accel_z),
    .out_tilted          (out_tilted),
    .out_fast_rate       (out_fast_rate),
    .out_reference_taken (out_reference_taken)
  );

  tilt_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_x_high_byte      (in_x_high_byte),
    .in_x_low_byte       (in_x_low_byte),
    .in_y_high_byte      (in_y_high_byte),
    .in_y_low_byte       (in_y_low_byte),
    .in_z_high_byte      (in_z_high_byte),
    .in_z_low_byte       (in_z_low_byte),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_accel_x         (out_accel_x),
    .out_accel_y         (out_accel_y),
    .out_accel_z         (out_accel_z),
    .out_tilted          (out_tilted),
    .out_fast_rate       (out_fast_rate),
    .out_reference_taken (out_reference_taken),
    .mismatches          (mismatches),
    .outstanding         (outstanding),
    .n_compared          (n_compared),
    .n_tilted            (n_tilted),
    .n_fast              (n_fast)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles", quiet_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_raw(input logic [7:0] xh, input logic [7:0] xl, input logic [7:0] yh,
                          input logic [7:0] yl, input logic [7:0] zh, input logic [7:0] zl);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_x_high_byte <= xh;
    in_x_low_byte  <= xl;
    in_y_high_byte <= yh;
    in_y_low_byte  <= yl;
    in_z_high_byte <= zh;
    in_z_low_byte  <= zl;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // bits below the sample get random values, they must be ignored
  task automatic send_axes(input int x, input int y, input int z);
    logic [15:0] wx, wy, wz;
    wx = (16'(x) << (16 - SAMPLE_BITS)) | 16'($urandom_range((1 << (16 - SAMPLE_BITS)) - 1));
    wy = (16'(y) << (16 - SAMPLE_BITS)) | 16'($urandom_range((1 << (16 - SAMPLE_BITS)) - 1));
    wz = (16'(z) << (16 - SAMPLE_BITS)) | 16'($urandom_range((1 << (16 - SAMPLE_BITS)) - 1));
    send_raw(wx[15:8], wx[7:0], wy[15:8], wy[7:0], wz[15:8], wz[7:0]);
  endtask

  function automatic int pick_extreme();
    case ($urandom_range(2))
      0: return AXIS_MIN;
      1: return AXIS_MAX;
      default: return 0;
    endcase
  endfunction

  function automatic int jitter(int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // reference is z-up; most words stay close to it so fast mode can expire
  task automatic random_word();
    int r;
    r = $urandom_range(99);
    if (r < 55)
      send_axes(jitter(300), jitter(300), ONE_G + jitter(300));
    else if (r < 70)
      send_axes(int'($urandom_range(ONE_G - 300, ONE_G + 300)), jitter(100), ONE_G + jitter(50));
    else if (r < 92)
      send_raw(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
               8'($urandom));
    else if (r < 96)
      send_axes(0, 0, 0);
    else
      send_axes(pick_extreme(), pick_extreme(), pick_extreme());
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int limit,
                           input int count);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= 8'(limit);
    @(posedge clk);
    cfg_we         <= 1'b0;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) random_word();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reference, then the angle corner cases under the reset hold limit
    send_axes(0, 0, ONE_G);
    send_axes(0, 0, ONE_G);
    send_axes(0, 0, 0);
    send_axes(AXIS_MAX, AXIS_MAX, AXIS_MAX);
    send_axes(AXIS_MIN, AXIS_MIN, AXIS_MIN);
    send_axes(ONE_G, 0, 0);
    send_axes(ONE_G, 0, ONE_G);
    send_axes(ONE_G - 1, 0, ONE_G);
    send_axes(ONE_G + 1, 0, ONE_G);
    send_axes(0, 0, AXIS_MIN);
    send_axes(0, 0, AXIS_MAX);
    repeat (12) send_axes(0, 0, ONE_G);

    run_phase(7, 58, 255, 120);
    repeat (3) send_axes(ONE_G, 0, 0);
    run_phase(58, 7, 0, 70);
    run_phase(58, 7, 3, 110);
    run_phase(0, 0, int'($urandom_range(1, 20)), 150);

    settle();
    repeat (16) @(posedge clk);
    $display("summary: %0d words sent under hold limits 10, 255, 0, 3 and a random one,",
             words_sent);
    $display("summary: %0d results compared, %0d tilted, %0d in fast mode",
             n_compared, n_tilted, n_fast);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
